// ===== rtl/sorted_unique_id_set_top_assert.svh =====
// Assertion macros shared by the sorted unique id set RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SORTED_UNIQUE_ID_SET_TOP_ASSERT_SVH
`define SORTED_UNIQUE_ID_SET_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SUIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");
// Next-cycle implication, disabled during reset.
`define SUIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");
`else
`define SUIS_ASSERT_NOW(label, clk, rst, ante, cons)
`define SUIS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/suis_pkg.sv =====
// Shared types and constants for the sorted unique id set.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package suis_pkg;

   localparam int ID_W      = 31;
   localparam int STATUS_W  = 3;
   localparam int DEPTH_DEF = 32;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_READ   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [ID_W-1:0] id;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_ELEMENT  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_READ
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/suis_front.sv =====
// Front end of the sorted unique id set: accepts requests, classifies them
// and holds them in a two-entry command queue. Depends on suis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module suis_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [31:0]             req_tdata,   // [30:0] id_value, [31] zero
   input  wire  [0:0]              req_tuser,   // [0] mode
   input  wire                     q_pop,
   output suis_pkg::queue_out_type q_out
);
   import suis_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff,   fill_in;
   logic       push;
   cmd_type    new_cmd;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      new_cmd.kind = req_tuser[0] ? CMD_READ : CMD_INSERT;
      new_cmd.id   = req_tdata[ID_W-1:0];
   end

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   assign q_out.valid = (fill_ff != 2'd0);
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/suis_back.sv =====
// Back end of the sorted unique id set: the sorted store with parallel
// compare and shift, the read-out sequencer and the result register.
// Depends on suis_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_unique_id_set_top_assert.svh"

module suis_back #(
   parameter int DEPTH = suis_pkg::DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  suis_pkg::queue_out_type q_out,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [31:0]             rsp_tdata,   // [30:0] element, [31] zero
   output logic [2:0]              rsp_tuser,   // [2:0] status
   output logic                    rsp_tlast
);
   import suis_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   back_state_type  state_ff, state_in;
   logic [ID_W-1:0] ent_ff [DEPTH];
   logic [ID_W-1:0] ent_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DEPTH-1:0] lt, lt_ff;
   logic [DEPTH-1:0] eq;
   logic             dup_ff;
   logic [ID_W-1:0]  id_ff;
   logic             full;
   logic             out_free;
   logic             ins_commit;
   logic             load_out;
   logic             read_last;
   status_type       out_status;
   logic [ID_W-1:0]  out_elem;
   logic             out_last;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [ID_W-1:0]  rsp_elem_ff;
   logic             rsp_last_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign read_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // Every valid cell compares against the queue head in parallel. The list is
   // sorted, so the less-than flags form a run starting at cell zero.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (ent_ff[i] <  q_out.cmd.id);
         eq[i] = (CNT_W'(i) < count_ff) && (ent_ff[i] == q_out.cmd.id);
      end
   end

   // Shift network: cells below the insert point keep their id, the first
   // cell at or above it takes the new id, the rest take their lower neighbor.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign ent_in[g] = lt_ff[g] ? ent_ff[g] : id_ff;
      end else begin : g_rest
         assign ent_in[g] = lt_ff[g]   ? ent_ff[g] :
                            lt_ff[g-1] ? id_ff     : ent_ff[g-1];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_out.valid) begin
               state_in = (q_out.cmd.kind == CMD_READ) ? BK_READ : BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            if (out_free && ((count_ff == '0) || read_last)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_pop      = 1'b0;
      load_out   = 1'b0;
      ins_commit = 1'b0;
      out_status = ST_INSERTED;
      out_elem   = '0;
      out_last   = 1'b1;
      idx_in     = idx_ff;
      count_in   = count_ff;
      case (state_ff)
         BK_IDLE: begin
            q_pop  = q_out.valid;
            idx_in = '0;
         end
         BK_UPDATE: begin
            load_out = out_free;
            if (dup_ff) begin
               out_status = ST_PRESENT;
            end else if (full) begin
               out_status = ST_FULL;
            end else begin
               out_status = ST_INSERTED;
               ins_commit = out_free;
            end
            if (ins_commit) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         BK_READ: begin
            load_out = out_free;
            if (count_ff == '0) begin
               out_status = ST_EMPTY;
            end else begin
               out_status = ST_ELEMENT;
               out_elem   = ent_ff[idx_ff];
               out_last   = read_last;
               if (out_free) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (q_pop && (q_out.cmd.kind == CMD_INSERT)) begin
         lt_ff  <= lt;
         dup_ff <= |eq;
         id_ff  <= q_out.cmd.id;
      end
      if (ins_commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            ent_ff[i] <= ent_in[i];
         end
      end
      if (load_out) begin
         rsp_status_ff <= out_status;
         rsp_elem_ff   <= out_elem;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_elem_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SUIS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `SUIS_ASSERT_NOW(a_pop_idle, clock, reset, q_pop, state_ff == BK_IDLE)
   `SUIS_ASSERT_NEXT(a_count_step, clock, reset, ins_commit,
                     count_ff == $past(count_ff) + CNT_W'(1))
   `SUIS_ASSERT_NOW(a_elem_in_range, clock, reset,
                    load_out && (out_status == ST_ELEMENT),
                    CNT_W'(idx_ff) < count_ff)

endmodule

`default_nettype wire

// ===== rtl/sorted_unique_id_set_top.sv =====
// An insert leaves the queue head in the compare stage (idle state, compare result
// registered) and is written and answered in the shift stage (update state); a read-out
// streams one element per cycle while the result channel does not stall. The back end
// pops the next command only after it is through with the current one.
// Reset (synchronous, active high) empties the list, the queue and the result
// register; the store contents are not cleared and are only read below count.
`timescale 1ns / 1ps
`default_nettype none

// Sorted unique id set. The block keeps an ascending list of ids without
// duplicates. An insert request (mode 0) either adds the id at its sorted
// position, reports that it was already present, or reports that the store is
// full and drops it. A read request (mode 1) streams the list in ascending order
// with tlast on the final element, or a single empty marker when nothing is stored.
//
// Structure: the front end takes requests into a two-entry command queue, so
// that new requests are accepted while the back end works or while a result
// waits to be taken. The back end compares the queue head against all stored
// ids in parallel, registers the outcome, then shifts the larger entries up and
// writes the new id once the output register is free. Results go through an output register.
module sorted_unique_id_set_top #(
   parameter int DEPTH = suis_pkg::DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [30:0] id_value, [31] zero
   input  wire  [0:0]  req_tuser,   // [0] mode
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] element, [31] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);
   import suis_pkg::*;

   queue_out_type q_out;
   logic          q_pop;

   // Front end: request acceptance, classification and the command queue.
   suis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_pop      (q_pop),
      .q_out      (q_out)
   );

   // Back end: sorted store, read-out sequencer and result register.
   suis_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== dv/tb_sorted_unique_id_set_top.sv =====
// Self-checking testbench for the sorted unique id set: random and directed insert
// and read requests against a cycle-free model of the sorted list.
// Depends on suis_pkg and sorted_unique_id_set_top only.
`timescale 1ns / 1ps

module tb_sorted_unique_id_set_top;
   import suis_pkg::*;

   localparam int DEPTH      = DEPTH_DEF;
   localparam int STALL_LIMIT = 2000;   // cycles without any handshake
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] element;
      logic            last;
   } id_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [30:0] id_value, [31] zero
   logic [0:0]  req_tuser  = '0;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [30:0] element, [31] zero
   logic [2:0]  rsp_tuser;          // [2:0] status
   logic        rsp_tlast;

   // Requests still to be sent, and results owed by the block in order.
   cmd_type       request_queue[$];
   id_result_type sorted_id_results[$];

   // Private copy of the sorted list.
   logic [ID_W-1:0] id_store[DEPTH];
   int              id_count = 0;

   cmd_type       drive_cmd;
   id_result_type want;
   int            req_hold = 0;
   int            rsp_hold = 0;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;

   sorted_unique_id_set_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Mostly short pauses, now and then a long one.
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Updates the sorted list for one accepted request and queues the results it owes.
   task automatic apply_id_request(input cmd_type cmd);
      id_result_type res;
      int            pos;
      int            i;
      res = '{status: ST_INSERTED, element: '0, last: 1'b1};
      if (cmd.kind == CMD_INSERT) begin
         pos = 0;
         while (pos < id_count && id_store[pos] < cmd.id) pos++;
         if (pos < id_count && id_store[pos] == cmd.id) begin
            res.status = ST_PRESENT;
         end else if (id_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            for (i = id_count; i > pos; i--) id_store[i] = id_store[i-1];
            id_store[pos] = cmd.id;
            id_count++;
         end
         sorted_id_results.push_back(res);
      end else if (id_count == 0) begin
         res.status = ST_EMPTY;
         sorted_id_results.push_back(res);
      end else begin
         for (i = 0; i < id_count; i++) begin
            res.status  = ST_ELEMENT;
            res.element = id_store[i];
            res.last    = (i == id_count - 1);
            sorted_id_results.push_back(res);
         end
      end
   endtask

   // Request side: one request on the bus at a time, held until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_id_request(drive_cmd);
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold = req_hold - 1;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               drive_cmd = request_queue.pop_front();
               req_tdata  <= {1'b0, drive_cmd.id};
               req_tuser  <= drive_cmd.kind;
               req_tvalid <= 1'b1;
               req_hold = req_calm ? 0 : idle_span();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: compare each result with the oldest one owed, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_id_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: status %0d element %h last %b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               want = sorted_id_results.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== {1'b0, want.element} ||
                   rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result mismatch: expected status %0d element %h last %b",
                              want.status, {1'b0, want.element}, want.last);
                     $display("                 got      status %0d element %h last %b",
                              rsp_tuser, rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_hold = idle_span();
            if ($urandom_range(0, 79) == 0) rsp_calm = !rsp_calm;
         end
      end
   end

   // Watchdog on stretches with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [ID_W-1:0] issued[$];
      logic [ID_W-1:0] base;
      cmd_type         cmd;
      int              pick;
      int              n;

      // Directed part: empty read-out, both ends of the id range, a duplicate,
      // a middle insert and alternating bit patterns.
      request_queue.push_back('{kind: CMD_READ,   id: ID_MAX});
      request_queue.push_back('{kind: CMD_INSERT, id: 31'd1000});
      request_queue.push_back('{kind: CMD_INSERT, id: '0});
      request_queue.push_back('{kind: CMD_INSERT, id: ID_MAX});
      request_queue.push_back('{kind: CMD_INSERT, id: '0});
      request_queue.push_back('{kind: CMD_INSERT, id: 31'd500});
      request_queue.push_back('{kind: CMD_READ,   id: '0});
      request_queue.push_back('{kind: CMD_INSERT, id: 31'h5555_5555});
      request_queue.push_back('{kind: CMD_INSERT, id: 31'h2AAA_AAAA});
      request_queue.push_back('{kind: CMD_INSERT, id: ID_MAX});
      request_queue.push_back('{kind: CMD_READ,   id: 31'h2AAA_AAAA});
      issued = '{31'd1000, 31'd0, ID_MAX, 31'd500, 31'h5555_5555, 31'h2AAA_AAAA};

      // Random part: mostly repeats of earlier ids and neighbors of them, with new
      // ids rare enough that the list fills part way through the run and then
      // exercises the full-list cases.
      for (n = 0; n < 400; n++) begin
         pick = $urandom_range(0, 99);
         cmd.id = ID_W'($urandom());
         if (pick < 30) begin
            cmd.kind = CMD_READ;
         end else begin
            cmd.kind = CMD_INSERT;
            base = issued[$urandom_range(0, issued.size() - 1)];
            if (pick < 42) begin
               cmd.id = (base == ID_MAX) ? base - 1'b1 : base + 1'b1;
               issued.push_back(cmd.id);
            end else if (pick < 46) begin
               cmd.id = (base == '0) ? base + 1'b1 : base - 1'b1;
               issued.push_back(cmd.id);
            end else if (pick < 50) begin
               issued.push_back(cmd.id);
            end else begin
               cmd.id = base;
            end
         end
         request_queue.push_back(cmd);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (sorted_id_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && sorted_id_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/suis_pkg.sv
rtl/suis_front.sv
rtl/suis_back.sv
rtl/sorted_unique_id_set_top.sv
dv/tb_sorted_unique_id_set_top.sv
